/* rtl/at_command_line_recognizer_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the AT command line recognizer.
// Each macro can be compiled out by defining ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef AT_COMMAND_LINE_RECOGNIZER_DEFINES_SVH
`define AT_COMMAND_LINE_RECOGNIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* rtl/atclr_pkg.sv */
// ---------------------------------------------------------------------------
// AT command line recognizer package
// Shared constants, codes and helpers of the recognizer.
// ---------------------------------------------------------------------------
package atclr_pkg;

  localparam int unsigned LineDepthDefault = 64;

  localparam logic [1:0] StInvalid = 2'd0;
  localparam logic [1:0] StOk      = 2'd1;
  localparam logic [1:0] StError   = 2'd2;

  localparam logic [2:0] CmdNone = 3'd0;
  localparam logic [2:0] CmdAt   = 3'd1;
  localparam logic [2:0] CmdAte0 = 3'd2;
  localparam logic [2:0] CmdAte1 = 3'd3;
  localparam logic [2:0] CmdSwv  = 3'd4;
  localparam logic [2:0] CmdTest = 3'd5;
  localparam logic [2:0] CmdQuit = 3'd6;
  localparam logic [2:0] CmdHelp = 3'd7;

  localparam logic [1:0] OpAction = 2'd0;
  localparam logic [1:0] OpQuery  = 2'd1;
  localparam logic [1:0] OpAssign = 2'd2;
  localparam logic [1:0] OpRange  = 2'd3;

  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChBs = 8'h08;

  // Lower-case a letter.
  function automatic logic [7:0] lower_ch(input logic [7:0] c);
    lower_ch = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  // Command name character at position p for command kind k; 0 past its end.
  // Kinds: 0 at, 1 ate1, 2 ate0, 3 at%swv, 4 at%test, 5 at%quit, 6 at%help.
  function automatic logic [7:0] name_ch(input logic [2:0] k, input logic [2:0] p);
    logic [7:0] c;
    c = 8'h00;
    case (p)
      3'd0: c = "a";
      3'd1: c = "t";
      3'd2: begin
        case (k)
          3'd0:    c = 8'h00;
          3'd1,
          3'd2:    c = "e";
          default: c = "%";
        endcase
      end
      3'd3: begin
        case (k)
          3'd1:    c = "1";
          3'd2:    c = "0";
          3'd3:    c = "s";
          3'd4:    c = "t";
          3'd5:    c = "q";
          3'd6:    c = "h";
          default: c = 8'h00;
        endcase
      end
      3'd4: begin
        case (k)
          3'd3:    c = "w";
          3'd4:    c = "e";
          3'd5:    c = "u";
          3'd6:    c = "e";
          default: c = 8'h00;
        endcase
      end
      3'd5: begin
        case (k)
          3'd3:    c = "v";
          3'd4:    c = "s";
          3'd5:    c = "i";
          3'd6:    c = "l";
          default: c = 8'h00;
        endcase
      end
      3'd6: begin
        case (k)
          3'd4:    c = "t";
          3'd5:    c = "t";
          3'd6:    c = "p";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    name_ch = c;
  endfunction

  // Length of command name k.
  function automatic logic [2:0] name_len(input logic [2:0] k);
    case (k)
      3'd0:    name_len = 3'd2;
      3'd1,
      3'd2:    name_len = 3'd4;
      3'd3:    name_len = 3'd6;
      default: name_len = 3'd7;
    endcase
  endfunction

  // Command code reported for kind k.
  function automatic logic [2:0] kind_cmd(input logic [2:0] k);
    case (k)
      3'd0:    kind_cmd = CmdAt;
      3'd1:    kind_cmd = CmdAte1;
      3'd2:    kind_cmd = CmdAte0;
      3'd3:    kind_cmd = CmdSwv;
      3'd4:    kind_cmd = CmdTest;
      3'd5:    kind_cmd = CmdQuit;
      default: kind_cmd = CmdHelp;
    endcase
  endfunction

endpackage

/* rtl/at_command_line_recognizer.sv */
// ---------------------------------------------------------------------------
// AT command line recognizer
// Collects received bytes into a line and recognizes AT commands at line end.
// ---------------------------------------------------------------------------
// Usage: one request on the input channel carries one received byte. Ordinary
// bytes are stored. Backspace steps back one place.
// CR or LF ends the line: the stored line is then walked one character at a
// time, each read and then checked, through a single compare and multiply-add
// unit. Command names are tried one after another (AT% first, then its four
// names, then AT, ATE1 and ATE0); then, for an AT% name, the suffix and, for
// TEST, the decimal argument are read before the result appears.
// After the result is delivered a clearing pass over all LINE_DEPTH places
// zeroes the memory, and no byte is taken meanwhile. After reset the same
// clearing pass runs before the first byte is accepted.
// The result sits in an output register; while the receiver stalls it holds
// and the block takes no new byte. Ordinary bytes give no result.
// ---------------------------------------------------------------------------
`include "at_command_line_recognizer_defines.svh"

module at_command_line_recognizer #(
  parameter int unsigned LINE_DEPTH = atclr_pkg::LineDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [2:0]  command_o,
  output logic [1:0]  operation_o,
  output logic [15:0] number_value_o,
  output logic [15:0] doubled_value_o
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned PW = AW + 1;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_NREQ   = 9'b000000100,
    S_NCMP   = 9'b000001000,
    S_SUFREQ = 9'b000010000,
    S_SUFCHK = 9'b000100000,
    S_DIGREQ = 9'b001000000,
    S_DIGCHK = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [7:0]      mem_q [LINE_DEPTH];
  logic [7:0]      rd_q;
  logic [PW-1:0]   wpos_q, wpos_d;
  logic [PW-1:0]   len_q, len_d;
  logic [PW-1:0]   ptr_q, ptr_d;
  logic [2:0]      kind_q, kind_d;
  logic [2:0]      cidx_q, cidx_d;
  logic            pct_q, pct_d;
  logic            eq_q, eq_d;
  logic [1:0]      sub_q, sub_d;
  logic [15:0]     val_q, val_d;
  logic [1:0]      st_q, st_d;
  logic [2:0]      cmd_q, cmd_d;
  logic [1:0]      op_q, op_d;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [7:0]      wdata;
  logic [AW-1:0]   raddr;
  logic [PW-1:0]   wpos_eff;
  logic            in_acc, out_acc;
  logic [7:0]      pat_c, lc_c;
  logic [19:0]     mac;
  logic [2:0]      pat_len;
  logic            beyond;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign wpos_eff = (wpos_q == PW'(LINE_DEPTH)) ? '0 : wpos_q;

  // Line memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  // Shared unit: pattern compare and decimal multiply-add.
  assign pat_c   = atclr_pkg::name_ch(kind_q, cidx_q);
  assign pat_len = atclr_pkg::name_len(kind_q);
  assign lc_c    = atclr_pkg::lower_ch(rd_q);
  assign mac     = {val_q, 3'b000} + {3'b000, val_q, 1'b0} + 20'(rd_q - 8'h30);
  assign beyond  = (ptr_q >= PW'(LINE_DEPTH));

  // Sequencer.
  always_comb begin
    state_d = state_q;
    wpos_d  = wpos_q;
    len_d   = len_q;
    ptr_d   = ptr_q;
    kind_d  = kind_q;
    cidx_d  = cidx_q;
    pct_d   = pct_q;
    eq_d    = eq_q;
    sub_d   = sub_q;
    val_d   = val_q;
    st_d    = st_q;
    cmd_d   = cmd_q;
    op_d    = op_q;
    we      = 1'b0;
    waddr   = wpos_eff[AW-1:0];
    wdata   = rx_byte_i;
    raddr   = ptr_q[AW-1:0];
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = ptr_q[AW-1:0];
        wdata = 8'h00;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == PW'(LINE_DEPTH - 1)) begin
          ptr_d   = '0;
          wpos_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (rx_byte_i == atclr_pkg::ChCr || rx_byte_i == atclr_pkg::ChLf) begin
            we      = 1'b1;
            wdata   = 8'h00;
            len_d   = wpos_eff;
            kind_d  = 3'd3;
            pct_d   = 1'b1;
            cidx_d  = '0;
            ptr_d   = '0;
            eq_d    = 1'b1;
            val_d   = '0;
            st_d    = atclr_pkg::StInvalid;
            cmd_d   = atclr_pkg::CmdNone;
            op_d    = atclr_pkg::OpAction;
            state_d = S_NREQ;
          end else if (rx_byte_i == atclr_pkg::ChBs) begin
            wpos_d = (wpos_eff != '0) ? wpos_eff - 1'b1 : wpos_eff;
          end else begin
            we     = 1'b1;
            wpos_d = wpos_eff + 1'b1;
          end
        end
      end
      // Read one line character for the name compare.
      S_NREQ: begin
        state_d = S_NCMP;
      end
      S_NCMP: begin
        // pct_q marks the AT% check (first three characters of kind 3).
        if ((pct_q && cidx_q == 3'd3) || (!pct_q && cidx_q == pat_len)) begin
          if (pct_q) begin
            pct_d  = 1'b0;
            cidx_d = '0;
            ptr_d  = '0;
            if (eq_q) begin
              kind_d = 3'd3;
            end else begin
              kind_d = 3'd0;
            end
            eq_d    = 1'b1;
            state_d = S_NREQ;
          end else if (kind_q >= 3'd3) begin
            // AT% name matched by prefix.
            if (eq_q) begin
              cmd_d   = atclr_pkg::kind_cmd(kind_q);
              st_d    = atclr_pkg::StOk;
              ptr_d   = PW'(pat_len);
              state_d = S_SUFREQ;
            end else if (kind_q == 3'd6) begin
              state_d = S_OUT;
            end else begin
              kind_d  = kind_q + 1'b1;
              cidx_d  = '0;
              ptr_d   = '0;
              eq_d    = 1'b1;
              state_d = S_NREQ;
            end
          end else begin
            // Exact match needs the terminator at the name end.
            if (eq_q && (beyond || rd_q == 8'h00)) begin
              cmd_d   = atclr_pkg::kind_cmd(kind_q);
              st_d    = atclr_pkg::StOk;
              state_d = S_OUT;
            end else if (kind_q == 3'd2) begin
              state_d = S_OUT;
            end else begin
              kind_d  = kind_q + 1'b1;
              cidx_d  = '0;
              ptr_d   = '0;
              eq_d    = 1'b1;
              state_d = S_NREQ;
            end
          end
        end else begin
          if (beyond || lc_c != pat_c) begin
            eq_d = 1'b0;
          end
          cidx_d  = cidx_q + 1'b1;
          ptr_d   = ptr_q + 1'b1;
          state_d = S_NREQ;
        end
      end
      S_SUFREQ: begin
        state_d = S_SUFCHK;
      end
      // sub_q: 0 first suffix char, 1 char after '='.
      S_SUFCHK: begin
        if (sub_q == 2'd0) begin
          if (ptr_q < len_q && rd_q == "?") begin
            op_d    = atclr_pkg::OpQuery;
            state_d = S_OUT;
          end else if (ptr_q < len_q && rd_q == "=") begin
            sub_d   = 2'd1;
            ptr_d   = ptr_q + 1'b1;
            state_d = S_SUFREQ;
          end else begin
            state_d = S_OUT;
          end
        end else begin
          sub_d = 2'd0;
          if (ptr_q < len_q && rd_q == "?") begin
            op_d    = atclr_pkg::OpRange;
            state_d = S_OUT;
          end else begin
            op_d    = atclr_pkg::OpAssign;
            state_d = (cmd_q == atclr_pkg::CmdTest) ? S_DIGREQ : S_OUT;
          end
        end
      end
      S_DIGREQ: begin
        state_d = S_DIGCHK;
      end
      S_DIGCHK: begin
        if (ptr_q < len_q && rd_q >= "0" && rd_q <= "9") begin
          val_d   = mac[15:0];
          ptr_d   = ptr_q + 1'b1;
          state_d = S_DIGREQ;
        end else begin
          if (val_q[15]) begin
            st_d = atclr_pkg::StError;
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          ptr_d   = '0;
          state_d = S_CLEAR;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      wpos_q  <= '0;
      ptr_q   <= '0;
      sub_q   <= '0;
    end else begin
      state_q <= state_d;
      wpos_q  <= wpos_d;
      ptr_q   <= ptr_d;
      sub_q   <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    kind_q <= kind_d;
    cidx_q <= cidx_d;
    pct_q  <= pct_d;
    eq_q   <= eq_d;
    val_q  <= val_d;
    st_q   <= st_d;
    cmd_q  <= cmd_d;
    op_q   <= op_d;
  end

  // Result register outputs.
  assign out_valid_o     = (state_q == S_OUT);
  assign status_o        = st_q;
  assign command_o       = cmd_q;
  assign operation_o     = op_q;
  assign number_value_o  = (cmd_q == atclr_pkg::CmdTest && op_q == atclr_pkg::OpAssign)
                           ? val_q : 16'd0;
  assign doubled_value_o = (cmd_q == atclr_pkg::CmdTest && op_q == atclr_pkg::OpAssign
                            && st_q == atclr_pkg::StOk) ? {val_q[14:0], 1'b0} : 16'd0;

  `ASSERT_NEVER(a_busy_accept, clk_i, rst_ni, in_acc && out_valid_o)
  `ASSERT_IMPL(a_out_clear, clk_i, rst_ni, out_acc |=> state_q == S_CLEAR)
  `ASSERT_NEVER(a_wpos_range, clk_i, rst_ni, wpos_q > PW'(LINE_DEPTH))

endmodule
